// ===== sv/tofstd_pkg.sv =====
// Shared types, constants and command codes for the time-of-flight slot sequencer.
`default_nettype none

package tofstd_pkg;

    localparam int SLOTS_DEFAULT = 4;

    localparam int CMD_W      = 2;
    localparam int OVF_W      = 24;
    localparam int TMR_W      = 16;
    localparam int SEQ_W      = 8;
    localparam int BYTE_W     = 8;
    localparam int BIDX_W     = 5;
    localparam int DELAY_W    = 11;
    localparam int DIFF_W     = 24;
    localparam int STAMP_W    = 32;
    localparam int SLOT_W     = 4;
    localparam int TICK_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam int S_TDATA_W = OVF_W + TMR_W + SEQ_W;
    localparam int M_TDATA_W = BYTE_W + BIDX_W + DELAY_W;

    localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EDGE    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_STATION_ID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_TICKS = 1'd1;

    localparam logic [STAMP_W-1:0] DIFF_LIMIT   = 32'd941177;
    localparam logic [DIFF_W-1:0]  DIFF_INVALID = 24'hFFFFFF;

    localparam logic [CFG_DATA_W-1:0] STATION_ID_RESET = 8'd1;
    localparam logic [CFG_DATA_W-1:0] SLOT_TICKS_RESET = 8'd18;

    // One request to the shared adder: result = a + b, or a - b when sub is set.
    typedef struct packed {
        logic [STAMP_W-1:0] a;
        logic [STAMP_W-1:0] b;
        logic               sub;
    } alu_req_t;

endpackage

`default_nettype wire

// ===== sv/tof_slot_time_difference_unit.sv =====
// Top level of the time-of-flight slot sequencer and report frame generator.
//
// This block takes one event transaction at a time on the s_ channel and writes
// report frame bytes on the m_ channel. Start, tick, timeout and unarmed edge
// transactions are accepted directly in the idle state. An armed ultrasonic edge
// keeps the block busy while both timestamps and their difference are worked
// out in five steps of one shared 32-bit adder and the result is stored. A
// report (after the edge in the last slot, or after a timeout) first computes
// the send delay on that same adder and then streams one frame byte per cycle,
// 2 + 3*SLOTS bytes, while the sink keeps m_tready high; the block accepts no
// new event until the last byte has been loaded into the output register. A
// finished byte waits in that register, so the next event can be taken while
// the final byte is still pending.
`default_nettype none

module tof_slot_time_difference_unit #(
    parameter int SLOTS = tofstd_pkg::SLOTS_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port.
    input  logic                                 cfg_wr_en,
    input  logic [tofstd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tofstd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Event input channel.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0 up: overflow_count[23:0], timer_count[39:24],
    // sequence_req[47:40].
    input  logic [tofstd_pkg::S_TDATA_W-1:0]     s_tdata,
    // Fields from bit 0 up: cmd[1:0].
    input  logic [tofstd_pkg::CMD_W-1:0]         s_tuser,
    // Report byte output channel.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0 up: frame_byte[7:0], byte_index[12:8], send_delay[23:13].
    output logic [tofstd_pkg::M_TDATA_W-1:0]     m_tdata,
    // Marks the last byte of the report frame.
    output logic                                 m_tlast
);
    import tofstd_pkg::*;

    localparam int IDXW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NBYTES = 2 + 3 * SLOTS;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS);
    localparam logic [BIDX_W-1:0] LAST_BYTE = BIDX_W'(NBYTES - 1);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EVT_A = 4'd1;  // event overflow * 10240
    localparam logic [3:0] ST_EVT_B = 4'd2;  // plus event timer
    localparam logic [3:0] ST_REF_A = 4'd3;  // reference overflow * 10240
    localparam logic [3:0] ST_REF_B = 4'd4;  // plus reference timer
    localparam logic [3:0] ST_DIFF  = 4'd5;  // event minus reference
    localparam logic [3:0] ST_STORE = 4'd6;  // clamp and store the difference
    localparam logic [3:0] ST_DELAY = 4'd7;  // send delay for the report
    localparam logic [3:0] ST_RPT   = 4'd8;  // stream the frame bytes

    logic [3:0]            state_reg, state_next;

    logic [CFG_DATA_W-1:0] station_id_reg;
    logic [CFG_DATA_W-1:0] slot_ticks_reg;

    logic [SLOT_W-1:0]     slot_reg;
    logic [TICK_W-1:0]     tick_count_reg;
    logic                  running_reg;
    logic                  armed_reg;
    logic [OVF_W-1:0]      ref_ovf_reg;
    logic [TMR_W-1:0]      ref_tmr_reg;
    logic [SEQ_W-1:0]      seq_latch_reg;
    logic [DIFF_W-1:0]     diff_reg [SLOTS];

    // Captured fields of the edge being processed.
    logic [OVF_W-1:0]      evt_ovf_reg;
    logic [TMR_W-1:0]      evt_tmr_reg;

    logic [STAMP_W-1:0]    acc_reg;
    logic [STAMP_W-1:0]    ref_acc_reg;
    logic [DELAY_W-1:0]    delay_reg;

    // Frame position: byte counter, difference slot and byte within it.
    logic [BIDX_W-1:0]     byte_cnt_reg;
    logic [IDXW-1:0]       dsel_reg;
    logic [1:0]            part_reg;

    logic                  m_valid_reg;
    logic [BYTE_W-1:0]     m_byte_reg;
    logic [BIDX_W-1:0]     m_bidx_reg;
    logic [DELAY_W-1:0]    m_delay_reg;
    logic                  m_last_reg;

    alu_req_t              alu_req;
    logic [STAMP_W-1:0]    alu_result;

    logic [CMD_W-1:0]      in_cmd;
    logic [OVF_W-1:0]      in_ovf;
    logic [TMR_W-1:0]      in_tmr;
    logic [SEQ_W-1:0]      in_seq;
    logic                  s_fire;

    logic [TICK_W-1:0]     tick_inc;
    logic [SLOT_W-1:0]     slot_inc;
    logic [SLOT_W-1:0]     slot_m1;
    logic [IDXW-1:0]       store_idx;
    logic [CFG_DATA_W-1:0] id_m1;
    logic [DIFF_W-1:0]     store_val;
    logic                  out_load;
    logic [BYTE_W-1:0]     rpt_byte;
    logic [DIFF_W-1:0]     rpt_diff;

    assign in_ovf = s_tdata[OVF_W-1:0];
    assign in_tmr = s_tdata[OVF_W+TMR_W-1:OVF_W];
    assign in_seq = s_tdata[S_TDATA_W-1:OVF_W+TMR_W];
    assign in_cmd = s_tuser;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    assign tick_inc  = tick_count_reg + 1'b1;
    assign slot_inc  = slot_reg + 1'b1;
    assign slot_m1   = slot_reg - 1'b1;
    assign store_idx = slot_m1[IDXW-1:0];
    assign id_m1     = station_id_reg - 1'b1;

    // The output register takes a new byte when it is empty or being drained.
    assign out_load = (state_reg == ST_RPT) && (!m_valid_reg || m_tready);

    // Operand selection for the shared adder. 10240 is 2^13 + 2^11.
    always_comb begin
        alu_req.a   = acc_reg;
        alu_req.b   = ref_acc_reg;
        alu_req.sub = 1'b0;
        case (state_reg)
            ST_EVT_A: begin
                alu_req.a = {evt_ovf_reg[STAMP_W-14:0], 13'd0};
                alu_req.b = {evt_ovf_reg[STAMP_W-12:0], 11'd0};
            end
            ST_EVT_B: begin
                alu_req.a = acc_reg;
                alu_req.b = {{(STAMP_W-TMR_W){1'b0}}, evt_tmr_reg};
            end
            ST_REF_A: begin
                alu_req.a = {ref_ovf_reg[STAMP_W-14:0], 13'd0};
                alu_req.b = {ref_ovf_reg[STAMP_W-12:0], 11'd0};
            end
            ST_REF_B: begin
                alu_req.a = ref_acc_reg;
                alu_req.b = {{(STAMP_W-TMR_W){1'b0}}, ref_tmr_reg};
            end
            ST_DIFF: begin
                alu_req.a   = acc_reg;
                alu_req.b   = ref_acc_reg;
                alu_req.sub = 1'b1;
            end
            ST_DELAY: begin
                // Five times (id - 1) as (id - 1) * 4 + (id - 1).
                alu_req.a = {{(STAMP_W-CFG_DATA_W-2){1'b0}}, id_m1, 2'd0};
                alu_req.b = {{(STAMP_W-CFG_DATA_W){1'b0}}, id_m1};
            end
            default: begin
                alu_req.a   = acc_reg;
                alu_req.b   = ref_acc_reg;
                alu_req.sub = 1'b0;
            end
        endcase
    end

    tofstd_alu u_alu (
        .req    (alu_req),
        .result (alu_result)
    );

    // A capture of all zeros stands for a missed edge and stores zero.
    always_comb begin
        if (evt_ovf_reg == '0 && evt_tmr_reg == '0) begin
            store_val = '0;
        end else if (acc_reg[STAMP_W-1] || acc_reg > DIFF_LIMIT) begin
            store_val = DIFF_INVALID;
        end else begin
            store_val = acc_reg[DIFF_W-1:0];
        end
    end

    assign rpt_diff = diff_reg[dsel_reg];

    always_comb begin
        if (byte_cnt_reg == '0) begin
            rpt_byte = seq_latch_reg;
        end else if (byte_cnt_reg == BIDX_W'(1)) begin
            rpt_byte = station_id_reg;
        end else begin
            case (part_reg)
                2'd0:    rpt_byte = rpt_diff[23:16];
                2'd1:    rpt_byte = rpt_diff[15:8];
                default: rpt_byte = rpt_diff[7:0];
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire && in_cmd == CMD_EDGE && armed_reg) begin
                    state_next = ST_EVT_A;
                end else if (s_fire && in_cmd == CMD_TIMEOUT) begin
                    state_next = ST_DELAY;
                end
            end
            ST_EVT_A: state_next = ST_EVT_B;
            ST_EVT_B: state_next = ST_REF_A;
            ST_REF_A: state_next = ST_REF_B;
            ST_REF_B: state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_STORE;
            ST_STORE: state_next = (slot_reg == LAST_SLOT) ? ST_DELAY : ST_IDLE;
            ST_DELAY: state_next = ST_RPT;
            ST_RPT: begin
                if (out_load && byte_cnt_reg == LAST_BYTE) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            station_id_reg <= STATION_ID_RESET;
            slot_ticks_reg <= SLOT_TICKS_RESET;
            slot_reg       <= SLOT_W'(1);
            tick_count_reg <= '0;
            running_reg    <= 1'b0;
            armed_reg      <= 1'b0;
            ref_ovf_reg    <= '0;
            ref_tmr_reg    <= '0;
            seq_latch_reg  <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                diff_reg[i] <= '0;
            end
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_STATION_ID: station_id_reg <= cfg_data;
                    REG_SLOT_TICKS: slot_ticks_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (s_fire) begin
                case (in_cmd)
                    CMD_START: begin
                        running_reg   <= 1'b1;
                        ref_ovf_reg   <= in_ovf;
                        ref_tmr_reg   <= in_tmr;
                        armed_reg     <= 1'b1;
                        slot_reg      <= SLOT_W'(1);
                        seq_latch_reg <= in_seq;
                    end
                    CMD_TICK: begin
                        if (running_reg) begin
                            if (tick_inc == slot_ticks_reg) begin
                                tick_count_reg <= '0;
                                ref_ovf_reg    <= in_ovf;
                                ref_tmr_reg    <= in_tmr;
                                armed_reg      <= 1'b1;
                                slot_reg       <= slot_inc;
                                if (slot_inc == LAST_SLOT) begin
                                    running_reg <= 1'b0;
                                end
                            end else begin
                                tick_count_reg <= tick_inc;
                            end
                        end
                    end
                    CMD_EDGE: begin
                        armed_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end

            if (state_reg == ST_STORE) begin
                if (slot_reg != '0 && slot_reg <= LAST_SLOT) begin
                    diff_reg[store_idx] <= store_val;
                end
                ref_ovf_reg <= '0;
                ref_tmr_reg <= '0;
            end

            // Differences clear once the last byte has left the frame counter.
            if (out_load && byte_cnt_reg == LAST_BYTE) begin
                for (int i = 0; i < SLOTS; i++) begin
                    diff_reg[i] <= '0;
                end
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            evt_ovf_reg <= in_ovf;
            evt_tmr_reg <= in_tmr;
        end

        case (state_reg)
            ST_EVT_A, ST_EVT_B, ST_DIFF: acc_reg <= alu_result;
            ST_REF_A, ST_REF_B:          ref_acc_reg <= alu_result;
            ST_DELAY: begin
                delay_reg    <= (station_id_reg == '0) ? '0 : alu_result[DELAY_W-1:0];
                byte_cnt_reg <= '0;
                dsel_reg     <= '0;
                part_reg     <= '0;
            end
            default: ;
        endcase

        if (out_load) begin
            m_byte_reg   <= rpt_byte;
            m_bidx_reg   <= byte_cnt_reg;
            m_delay_reg  <= delay_reg;
            m_last_reg   <= (byte_cnt_reg == LAST_BYTE);
            byte_cnt_reg <= byte_cnt_reg + 1'b1;
            if (byte_cnt_reg >= BIDX_W'(2)) begin
                if (part_reg == 2'd2) begin
                    part_reg <= '0;
                    dsel_reg <= dsel_reg + 1'b1;
                end else begin
                    part_reg <= part_reg + 1'b1;
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_delay_reg, m_bidx_reg, m_byte_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ===== sv/tofstd_alu.sv =====
// Shared 32-bit add/subtract unit used by the sequencer for the timestamp, difference and send delay steps.
`default_nettype none

module tofstd_alu (
    input  tofstd_pkg::alu_req_t            req,
    output logic [tofstd_pkg::STAMP_W-1:0]  result
);
    import tofstd_pkg::*;

    always_comb begin
        if (req.sub) begin
            result = req.a - req.b;
        end else begin
            result = req.a + req.b;
        end
    end

endmodule

`default_nettype wire

// ===== sv/tofstd_checker.sv =====
// Port-level assertions for the slot sequencer and the bind that attaches them.
`default_nettype none

module tofstd_checker #(
    parameter int SLOTS = tofstd_pkg::SLOTS_DEFAULT
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [tofstd_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                              m_tlast
);
    import tofstd_pkg::*;

    localparam logic [BIDX_W-1:0] LAST_BYTE = BIDX_W'(2 + 3 * SLOTS - 1);

    // A stalled byte holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output byte changed while stalled");

    // The last flag sits exactly on the final frame position.
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[12:8] == LAST_BYTE)))
        else $error("last flag does not match byte position");

    // Inside a frame the next byte follows at once with the next index.
    a_frame_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[12:8] == $past(m_tdata[12:8]) + 1'b1))
        else $error("frame bytes not contiguous");

    // No event is taken while a frame is still being streamed.
    a_busy_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a frame");

endmodule

bind tof_slot_time_difference_unit tofstd_checker #(.SLOTS(SLOTS)) u_tofstd_checker (.*);

`default_nettype wire
